FILE: rtl/core/multi_channel_periodic_tick_timer_unit_macros.svh
// Assertion macros for the multi-channel periodic tick timer.
// Used by the top level; expects signals named clock and reset in scope.
`ifndef MULTI_CHANNEL_PERIODIC_TICK_TIMER_UNIT_MACROS_SVH
`define MULTI_CHANNEL_PERIODIC_TICK_TIMER_UNIT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define MCTT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check that a condition is followed by another in the next cycle.
`define MCTT_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

FILE: rtl/core/mctt_pkg.sv
// Package of the multi-channel periodic tick timer: widths, command and
// register codes, configuration and result structs. No dependencies.
`default_nettype none
package mctt_pkg;

   localparam int unsigned DEF_NUM_TIMERS = 4;
   localparam int unsigned MAX_TIMERS     = 4;
   localparam int unsigned TICK_W         = 32;
   localparam int unsigned TPS_W          = 20;
   localparam int unsigned TPMS_W         = 8;
   localparam int unsigned TREG_W         = 3;
   localparam int unsigned CSR_IDX_W      = 3;
   localparam int unsigned CSR_DATA_W     = 32;

   typedef enum logic [1:0] {
      CMD_TICK    = 2'd0,
      CMD_ENABLE  = 2'd1,
      CMD_DISABLE = 2'd2,
      CMD_NONE    = 2'd3
   } cmd_type;

   localparam logic [CSR_IDX_W-1:0] REG_INTERVAL_END  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_TIMERS_REG    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_TICKS_PER_SEC = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_TICKS_PER_MS  = 3'd6;

   localparam logic [TPS_W-1:0]  TPS_RESET  = 20'd1000;
   localparam logic [TPMS_W-1:0] TPMS_RESET = 8'd1;

   typedef struct packed {
      logic [TREG_W-1:0] timers_registered;
      logic [TPS_W-1:0]  ticks_per_second;
      logic [TPMS_W-1:0] ticks_per_millisecond;
   } cfg_type;

   typedef struct packed {
      logic [MAX_TIMERS-1:0] fire_mask;
      logic                  command_ok;
      logic [TICK_W-1:0]     tick_count;
      logic [TICK_W-1:0]     msec_count;
   } result_type;

endpackage
`default_nettype wire

FILE: rtl/core/mctt_ifs.sv
// Channel interfaces of the tick timer: request, response, register write.
// Depends on mctt_pkg.
`default_nettype none
interface mctt_req_if;
   import mctt_pkg::*;
   logic            valid;
   logic            ready;
   cmd_type         cmd;
   logic [1:0]      timer_index;
   modport source (output valid, cmd, timer_index, input ready);
   modport sink   (input valid, cmd, timer_index, output ready);
endinterface

interface mctt_rsp_if;
   import mctt_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [MAX_TIMERS-1:0] fire_mask;
   logic                  command_ok;
   logic [TICK_W-1:0]     tick_count;
   logic [TICK_W-1:0]     msec_count;
   modport source (output valid, fire_mask, command_ok, tick_count, msec_count, input ready);
   modport sink   (input valid, fire_mask, command_ok, tick_count, msec_count, output ready);
endinterface

interface mctt_csr_if;
   import mctt_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/mctt_rem_unit.sv
// Iterative restoring remainder unit: tick count modulo ticks per second,
// one quotient bit per cycle. Depends on mctt_pkg.
`default_nettype none
module mctt_rem_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [mctt_pkg::TICK_W-1:0] dividend,
   input  logic [mctt_pkg::TPS_W-1:0]  divisor,
   output logic                       done,
   output logic [mctt_pkg::TPS_W-1:0]  remainder
);
   import mctt_pkg::*;

   localparam int unsigned CW = $clog2(TICK_W + 1);

   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [TICK_W-1:0] q_ff, q_in;
   logic [TPS_W:0]    r_ff, r_in;
   logic [TPS_W-1:0]  d_ff, d_in;
   logic              done_ff, done_in;
   logic [TPS_W:0]    trial;

   assign trial = {r_ff[TPS_W-1:0], q_ff[TICK_W-1]};

   always_comb begin
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      done_in = 1'b0;
      if (start) begin
         cnt_in = CW'(TICK_W);
         q_in   = dividend;
         r_in   = '0;
         d_in   = divisor;
      end else if (cnt_ff != '0) begin
         r_in    = (trial >= {1'b0, d_ff}) ? trial - {1'b0, d_ff} : trial;
         q_in    = {q_ff[TICK_W-2:0], 1'b0};
         cnt_in  = cnt_ff - CW'(1);
         done_in = (cnt_ff == CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign done      = done_ff;
   assign remainder = r_ff[TPS_W-1:0];

endmodule
`default_nettype wire

FILE: rtl/core/mctt_core.sv
// Sequencer of the tick timer: counters, due times, enables and one shared
// 32-bit adder swept over the timers. Depends on mctt_pkg and mctt_rem_unit.
`default_nettype none
module mctt_core #(
   parameter int unsigned NUM_TIMERS = mctt_pkg::DEF_NUM_TIMERS
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   input  mctt_pkg::cmd_type                        cmd,
   input  logic [1:0]                               timer_index,
   input  mctt_pkg::cfg_type                        cfg,
   input  logic [NUM_TIMERS-1:0][mctt_pkg::TICK_W-1:0] interval,
   output logic                                     idle,
   output logic                                     res_valid,
   input  logic                                     res_take,
   output mctt_pkg::result_type                     res
);
   import mctt_pkg::*;

   localparam int unsigned TW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DECODE, ST_INC, ST_CHECK, ST_ADJ, ST_REM, ST_BASE, ST_FIN, ST_DONE
   } state_type;

   state_type                         state_ff, state_in;
   cmd_type                           cmd_ff, cmd_in;
   logic [1:0]                        idx_ff, idx_in;
   logic [TICK_W-1:0]                 tick_ff, tick_in;
   logic [TICK_W-1:0]                 msec_ff, msec_in;
   logic [TPMS_W-1:0]                 sub_ff, sub_in;
   logic [NUM_TIMERS-1:0][TICK_W-1:0] due_ff, due_in;
   logic [NUM_TIMERS-1:0]             en_ff, en_in;
   logic [TW-1:0]                     t_ff, t_in;
   logic [TICK_W-1:0]                 nxt_ff, nxt_in;
   logic [TICK_W-1:0]                 acc_ff, acc_in;
   logic [MAX_TIMERS-1:0]             mask_ff, mask_in;
   logic                              ok_ff, ok_in;

   logic [TREG_W-1:0] valid_cnt;
   logic              idx_ok;
   logic [TW-1:0]     sel;
   logic [TPS_W-1:0]  tps_eff;
   logic              align;
   logic              t_last;
   logic [TICK_W-1:0] add_a, add_b, sum;
   logic              rem_start, rem_done;
   logic [TPS_W-1:0]  rem;

   assign valid_cnt = (cfg.timers_registered > TREG_W'(NUM_TIMERS)) ?
                      TREG_W'(NUM_TIMERS) : cfg.timers_registered;
   assign idx_ok    = TREG_W'(idx_ff) < valid_cnt;
   assign sel       = idx_ok ? idx_ff[TW-1:0] : '0;
   assign tps_eff   = (cfg.ticks_per_second == '0) ? TPS_W'(1) : cfg.ticks_per_second;
   assign align     = interval[sel] >= TICK_W'(tps_eff);
   assign t_last    = (t_ff == TW'(NUM_TIMERS - 1));
   assign rem_start = (state_ff == ST_DECODE) && (cmd_ff == CMD_ENABLE) && idx_ok && align;

   mctt_rem_unit u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (tick_ff),
      .divisor   (tps_eff),
      .done      (rem_done),
      .remainder (rem)
   );

   always_comb begin
      unique case (state_ff)
         ST_INC: begin
            add_a = tick_ff;
            add_b = TICK_W'(1);
         end
         ST_CHECK: begin
            add_a = due_ff[t_ff];
            add_b = interval[t_ff];
         end
         ST_ADJ: begin
            add_a = tick_ff;
            add_b = interval[t_ff];
         end
         ST_BASE: begin
            add_a = tick_ff;
            add_b = TICK_W'(tps_eff - rem);
         end
         ST_FIN: begin
            add_a = acc_ff;
            add_b = interval[sel];
         end
         default: begin
            add_a = tick_ff;
            add_b = '0;
         end
      endcase
   end

   assign sum = add_a + add_b;

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      idx_in   = idx_ff;
      tick_in  = tick_ff;
      msec_in  = msec_ff;
      sub_in   = sub_ff;
      due_in   = due_ff;
      en_in    = en_ff;
      t_in     = t_ff;
      nxt_in   = nxt_ff;
      acc_in   = acc_ff;
      mask_in  = mask_ff;
      ok_in    = ok_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd_in   = cmd;
               idx_in   = timer_index;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            mask_in  = '0;
            ok_in    = 1'b0;
            acc_in   = tick_ff;
            state_in = ST_DONE;
            unique case (cmd_ff)
               CMD_TICK: state_in = ST_INC;
               CMD_ENABLE: begin
                  if (idx_ok) state_in = align ? ST_REM : ST_FIN;
               end
               CMD_DISABLE: begin
                  if (idx_ok) begin
                     en_in[sel] = 1'b0;
                     ok_in      = 1'b1;
                  end
               end
               CMD_NONE: state_in = ST_DONE;
            endcase
         end
         ST_INC: begin
            tick_in = sum;
            if (sub_ff == cfg.ticks_per_millisecond - TPMS_W'(1)) begin
               sub_in  = '0;
               msec_in = msec_ff + TICK_W'(1);
            end else begin
               sub_in = sub_ff + TPMS_W'(1);
            end
            t_in     = '0;
            ok_in    = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (en_ff[t_ff] && (tick_ff >= due_ff[t_ff])) begin
               nxt_in   = sum;
               mask_in  = mask_ff | (MAX_TIMERS'(1) << t_ff);
               state_in = ST_ADJ;
            end else if (t_last) begin
               state_in = ST_DONE;
            end else begin
               t_in = t_ff + TW'(1);
            end
         end
         ST_ADJ: begin
            due_in[t_ff] = (nxt_ff <= tick_ff) ? sum : nxt_ff;
            if (t_last) begin
               state_in = ST_DONE;
            end else begin
               t_in     = t_ff + TW'(1);
               state_in = ST_CHECK;
            end
         end
         ST_REM: begin
            if (rem_done) state_in = ST_BASE;
         end
         ST_BASE: begin
            acc_in   = sum;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            due_in[sel] = sum;
            en_in[sel]  = 1'b1;
            ok_in       = 1'b1;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (res_take) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tick_ff  <= '0;
         msec_ff  <= '0;
         sub_ff   <= '0;
         due_ff   <= '0;
         en_ff    <= '0;
      end else begin
         state_ff <= state_in;
         tick_ff  <= tick_in;
         msec_ff  <= msec_in;
         sub_ff   <= sub_in;
         due_ff   <= due_in;
         en_ff    <= en_in;
      end
      cmd_ff  <= cmd_in;
      idx_ff  <= idx_in;
      t_ff    <= t_in;
      nxt_ff  <= nxt_in;
      acc_ff  <= acc_in;
      mask_ff <= mask_in;
      ok_ff   <= ok_in;
   end

   assign idle           = (state_ff == ST_IDLE);
   assign res_valid      = (state_ff == ST_DONE);
   assign res.fire_mask  = mask_ff;
   assign res.command_ok = ok_ff;
   assign res.tick_count = tick_ff;
   assign res.msec_count = msec_ff;

endmodule
`default_nettype wire

FILE: rtl/core/multi_channel_periodic_tick_timer_unit.sv
// Multi-channel periodic tick timer: top level with register file, output
// register and checks. Depends on mctt_pkg, mctt_ifs, mctt_core and the macros.
//
// Channels: req_ch takes one transaction per command (tick, enable, disable,
// none), rsp_ch returns exactly one transaction per command with the fire
// mask, a command status and the tick and millisecond counts after the command.
// csr_ch writes the interval, registration and tick-rate registers; it is
// always ready and must be written only while no command is outstanding;
// the block does not enforce this. A tick steps through decode, increment and
// a check of each timer, plus an adjust step per firing timer; a disable or
// refused command goes from decode to done; an enable sets the due time in a
// final step, after the bit-per-cycle remainder unit when aligned to a second.
// One command is in flight at a time; req_ch.ready is high only when the
// sequencer is idle. A finished response sits in the output register, so the
// next request is taken while rsp_ch is stalled; that request then waits in
// the sequencer until the output register frees up.
// Reset clears counters, due times, enables and registers to their defaults.
`default_nettype none
`include "multi_channel_periodic_tick_timer_unit_macros.svh"
module multi_channel_periodic_tick_timer_unit #(
   parameter int unsigned NUM_TIMERS = mctt_pkg::DEF_NUM_TIMERS
) (
   input logic        clock,
   input logic        reset,
   mctt_req_if.sink   req_ch,
   mctt_rsp_if.source rsp_ch,
   mctt_csr_if.sink   csr_ch
);
   import mctt_pkg::*;

   localparam int unsigned TW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

   logic [NUM_TIMERS-1:0][TICK_W-1:0] interval_ff;
   cfg_type                           cfg_ff;
   logic                              rsp_valid_ff, rsp_valid_in;
   result_type                        rsp_ff;
   result_type                        core_res;
   logic                              core_idle, core_valid, core_take;
   logic                              csr_we;

   assign csr_ch.ready = 1'b1;
   assign csr_we       = csr_ch.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= '0;
         cfg_ff.timers_registered     <= '0;
         cfg_ff.ticks_per_second      <= TPS_RESET;
         cfg_ff.ticks_per_millisecond <= TPMS_RESET;
      end else if (csr_we) begin
         priority if (csr_ch.index < REG_INTERVAL_END) begin
            if (csr_ch.index < CSR_IDX_W'(NUM_TIMERS)) begin
               interval_ff[csr_ch.index[TW-1:0]] <= csr_ch.data;
            end
         end else if (csr_ch.index == REG_TIMERS_REG) begin
            cfg_ff.timers_registered <= csr_ch.data[TREG_W-1:0];
         end else if (csr_ch.index == REG_TICKS_PER_SEC) begin
            cfg_ff.ticks_per_second <= csr_ch.data[TPS_W-1:0];
         end else if (csr_ch.index == REG_TICKS_PER_MS) begin
            cfg_ff.ticks_per_millisecond <= csr_ch.data[TPMS_W-1:0];
         end
      end
   end

   mctt_core #(
      .NUM_TIMERS (NUM_TIMERS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .start       (req_ch.valid && req_ch.ready),
      .cmd         (req_ch.cmd),
      .timer_index (req_ch.timer_index),
      .cfg         (cfg_ff),
      .interval    (interval_ff),
      .idle        (core_idle),
      .res_valid   (core_valid),
      .res_take    (core_take),
      .res         (core_res)
   );

   assign req_ch.ready = core_idle;
   assign core_take    = core_valid && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ch.ready) rsp_valid_in = 1'b0;
      if (core_take) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (core_take) rsp_ff <= core_res;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.fire_mask  = rsp_ff.fire_mask;
   assign rsp_ch.command_ok = rsp_ff.command_ok;
   assign rsp_ch.tick_count = rsp_ff.tick_count;
   assign rsp_ch.msec_count = rsp_ff.msec_count;

   `MCTT_ASSERT_NEXT(a_busy_after_accept, req_ch.valid && req_ch.ready, !req_ch.ready, "ready while a command is in flight")
   `MCTT_ASSERT(a_mask_needs_ok, (rsp_ch.valid && !rsp_ch.command_ok) |-> (rsp_ch.fire_mask == '0), "fire mask on a refused command")
   `MCTT_ASSERT(a_mask_range, rsp_ch.valid |-> ((rsp_ch.fire_mask >> NUM_TIMERS) == '0), "fire bit beyond implemented timers")

endmodule
`default_nettype wire

FILE: test/multi_channel_periodic_tick_timer_unit_tb.sv
`timescale 1ns / 100ps
// Testbench for multi_channel_periodic_tick_timer_unit: directed and random commands with
// a shadow timer model that predicts every response. Needs mctt_pkg, mctt_ifs, the DUT.
module multi_channel_periodic_tick_timer_unit_tb;
   import mctt_pkg::*;

   localparam logic [CSR_IDX_W-1:0] REG_INTERVAL0 = 3'd0;
   localparam int unsigned CYCLE_LIMIT  = 1000000;
   localparam int unsigned TAIL_CYCLES  = 64;
   localparam int unsigned PHASES       = 12;
   localparam int unsigned PHASE_ITEMS  = 150;

   logic clock;
   logic reset;

   mctt_req_if req_ch();
   mctt_rsp_if rsp_ch();
   mctt_csr_if csr_ch();

   multi_channel_periodic_tick_timer_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // shadow registers and timer state
   logic [TICK_W-1:0] cfg_interval [MAX_TIMERS];
   logic [TREG_W-1:0] cfg_treg;
   logic [TPS_W-1:0]  cfg_tps;
   logic [TPMS_W-1:0] cfg_tpms;

   logic [TICK_W-1:0] shadow_ticks;
   logic [TICK_W-1:0] shadow_due [MAX_TIMERS];
   logic              shadow_on [MAX_TIMERS];
   logic [TPMS_W-1:0] shadow_sub;
   logic [TICK_W-1:0] shadow_msec;

   result_type  pending_results [$];
   int unsigned mismatch_count;
   int unsigned cycle_count;
   bit          no_stalls;

   function automatic result_type predict_result(input cmd_type cmd, input logic [1:0] idx);
      result_type        res;
      logic [TICK_W-1:0] tps_eff;
      logic [TICK_W-1:0] iv;
      logic [TICK_W-1:0] nxt;
      logic [TPMS_W-1:0] sub_top;
      logic [TREG_W-1:0] active;
      res = '0;
      active = (cfg_treg > TREG_W'(DEF_NUM_TIMERS)) ? TREG_W'(DEF_NUM_TIMERS) : cfg_treg;
      case (cmd)
         CMD_TICK: begin
            shadow_ticks = shadow_ticks + 1;
            for (int t = 0; t < DEF_NUM_TIMERS; t++) begin
               if (shadow_on[t] && shadow_ticks >= shadow_due[t]) begin
                  nxt = shadow_due[t] + cfg_interval[t];
                  if (nxt <= shadow_ticks) nxt = shadow_ticks + cfg_interval[t];
                  shadow_due[t] = nxt;
                  res.fire_mask[t] = 1'b1;
               end
            end
            sub_top = cfg_tpms - 8'd1;
            if (shadow_sub == sub_top) begin
               shadow_sub = '0;
               shadow_msec = shadow_msec + 1;
            end else begin
               shadow_sub = shadow_sub + 8'd1;
            end
            res.command_ok = 1'b1;
         end
         CMD_ENABLE, CMD_DISABLE: begin
            if ({1'b0, idx} < active) begin
               if (cmd == CMD_ENABLE) begin
                  iv = cfg_interval[idx];
                  tps_eff = (cfg_tps == '0) ? 32'd1 : TICK_W'(cfg_tps);
                  if (iv >= tps_eff) begin
                     shadow_due[idx] = shadow_ticks + tps_eff - (shadow_ticks % tps_eff) + iv;
                  end else begin
                     shadow_due[idx] = shadow_ticks + iv;
                  end
                  shadow_on[idx] = 1'b1;
               end else begin
                  shadow_on[idx] = 1'b0;
               end
               res.command_ok = 1'b1;
            end
         end
         default: ;
      endcase
      res.tick_count = shadow_ticks;
      res.msec_count = shadow_msec;
      return res;
   endfunction

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("multi_channel_periodic_tick_timer_unit regression: fail");
         $finish;
      end
   end

   initial begin
      wait (reset === 1'b0);
      forever begin
         if (!no_stalls && $urandom_range(0, 2) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         repeat ($urandom_range(1, 24)) @(posedge clock);
      end
   end

   task automatic report_mismatch(input string what, input result_type exp);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0s: expected mask %h ok %b ticks %h msec %h, got mask %h ok %b ticks %h msec %h",
                  what, exp.fire_mask, exp.command_ok, exp.tick_count, exp.msec_count,
                  rsp_ch.fire_mask, rsp_ch.command_ok, rsp_ch.tick_count, rsp_ch.msec_count);
      end
   endtask

   always @(posedge clock) begin
      result_type exp;
      if (reset === 1'b0 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected transaction", '0);
         end else begin
            exp = pending_results.pop_front();
            if (rsp_ch.fire_mask !== exp.fire_mask || rsp_ch.command_ok !== exp.command_ok ||
                rsp_ch.tick_count !== exp.tick_count || rsp_ch.msec_count !== exp.msec_count)
               report_mismatch("transaction mismatch", exp);
         end
      end
   end

   task automatic send_command(input cmd_type cmd, input logic [1:0] idx);
      if (!no_stalls && $urandom_range(0, 4) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.cmd         <= cmd;
      req_ch.timer_index <= idx;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      pending_results.push_back(predict_result(cmd, idx));
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data  <= value;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      if (index < REG_INTERVAL_END) cfg_interval[index] = value;
      else if (index == REG_TIMERS_REG) cfg_treg = value[TREG_W-1:0];
      else if (index == REG_TICKS_PER_SEC) cfg_tps = value[TPS_W-1:0];
      else if (index == REG_TICKS_PER_MS) cfg_tpms = value[TPMS_W-1:0];
   endtask

   task automatic close_writes();
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [TICK_W-1:0] pick_interval();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return $urandom_range(0, 12);
         6, 7:             return $urandom_range(0, 40);
         8:                return $urandom;
         default:          return 32'hFFFF_FFFF - $urandom_range(0, 8);
      endcase
   endfunction

   function automatic logic [TPS_W-1:0] pick_tps();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return 20'hFFFFF;
         2:       return 20'd1000000;
         3:       return TPS_W'($urandom_range(0, 20'hFFFFF));
         default: return TPS_W'($urandom_range(1, 16));
      endcase
   endfunction

   function automatic logic [TPMS_W-1:0] pick_tpms();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return 8'hFF;
         2:       return TPMS_W'($urandom_range(0, 255));
         default: return TPMS_W'($urandom_range(1, 4));
      endcase
   endfunction

   task automatic test_refused_at_defaults();
      send_command(CMD_TICK, 2'd0);
      send_command(CMD_ENABLE, 2'd0);
      send_command(CMD_DISABLE, 2'd3);
      send_command(CMD_NONE, 2'd1);
   endtask

   task automatic test_periodic_firing();
      wait_idle();
      write_register(REG_INTERVAL0 + 3'd0, 32'd0);
      write_register(REG_INTERVAL0 + 3'd1, 32'd1);
      write_register(REG_INTERVAL0 + 3'd2, 32'd3);
      write_register(REG_INTERVAL0 + 3'd3, 32'd2);
      write_register(REG_TIMERS_REG, 32'd4);
      close_writes();
      for (int t = 0; t < DEF_NUM_TIMERS; t++) send_command(CMD_ENABLE, 2'(t));
      repeat (4) send_command(CMD_TICK, 2'd3);
      send_command(CMD_DISABLE, 2'd2);
   endtask

   task automatic test_alignment_and_wrap();
      wait_idle();
      write_register(REG_INTERVAL0 + 3'd0, 32'd5);
      write_register(REG_INTERVAL0 + 3'd1, 32'hFFFF_FFFF);
      write_register(REG_TIMERS_REG, 32'd7);
      write_register(REG_TICKS_PER_SEC, 32'd0);
      write_register(REG_TICKS_PER_MS, 32'd0);
      close_writes();
      send_command(CMD_ENABLE, 2'd0);
      send_command(CMD_ENABLE, 2'd1);
      send_command(CMD_TICK, 2'd2);
      send_command(CMD_TICK, 2'd1);
      send_command(CMD_ENABLE, 2'd3);
      wait_idle();
      write_register(REG_INTERVAL0 + 3'd2, 32'h0010_0000);
      write_register(REG_TICKS_PER_SEC, 32'h000F_FFFF);
      close_writes();
      send_command(CMD_ENABLE, 2'd2);
      send_command(CMD_TICK, 2'd0);
   endtask

   task automatic test_lowered_registration();
      wait_idle();
      write_register(REG_TIMERS_REG, 32'd1);
      write_register(REG_TICKS_PER_MS, 32'd255);
      close_writes();
      send_command(CMD_ENABLE, 2'd2);
      send_command(CMD_DISABLE, 2'd1);
      send_command(CMD_TICK, 2'd1);
      send_command(CMD_DISABLE, 2'd0);
      send_command(CMD_TICK, 2'd3);
   endtask

   task automatic test_random_traffic();
      int unsigned roll;
      for (int p = 0; p < PHASES; p++) begin
         wait_idle();
         if (p == PHASES - 1) no_stalls = 1'b1;
         for (int t = 0; t < DEF_NUM_TIMERS; t++) begin
            write_register(REG_INTERVAL0 + 3'(t),
                           (p == 0) ? 32'd0 : (p == 1) ? 32'hFFFF_FFFF : pick_interval());
         end
         write_register(REG_TIMERS_REG, (p == 0) ? 32'd0 : (p == 1) ? 32'd7 :
                        ($urandom_range(0, 1) != 0) ? 32'd4 : 32'($urandom_range(0, 7)));
         write_register(REG_TICKS_PER_SEC, (p == 0) ? 32'd0 : (p == 1) ? 32'h000F_FFFF :
                        32'(pick_tps()));
         write_register(REG_TICKS_PER_MS, (p == 0) ? 32'd0 : (p == 1) ? 32'd255 :
                        32'(pick_tpms()));
         close_writes();
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 62) send_command(CMD_TICK, 2'($urandom_range(0, 3)));
            else if (roll < 78) send_command(CMD_ENABLE, 2'($urandom_range(0, 3)));
            else if (roll < 90) send_command(CMD_DISABLE, 2'($urandom_range(0, 3)));
            else send_command(CMD_NONE, 2'($urandom_range(0, 3)));
         end
      end
   endtask

   initial begin
      cycle_count = 0;
      mismatch_count = 0;
      no_stalls = 1'b0;
      for (int t = 0; t < MAX_TIMERS; t++) begin
         cfg_interval[t] = '0;
         shadow_due[t] = '0;
         shadow_on[t] = 1'b0;
      end
      cfg_treg = '0;
      cfg_tps = TPS_RESET;
      cfg_tpms = TPMS_RESET;
      shadow_ticks = '0;
      shadow_sub = '0;
      shadow_msec = '0;
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.cmd         <= CMD_TICK;
      req_ch.timer_index <= 2'd0;
      rsp_ch.ready       <= 1'b0;
      csr_ch.valid       <= 1'b0;
      csr_ch.index       <= REG_INTERVAL0;
      csr_ch.data        <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_refused_at_defaults();
      test_periodic_firing();
      test_alignment_and_wrap();
      test_lowered_registration();
      test_random_traffic();
      wait_idle();

      if (mismatch_count == 0) begin
         $display("multi_channel_periodic_tick_timer_unit regression: pass");
      end else begin
         $display("multi_channel_periodic_tick_timer_unit regression: fail");
      end
      $finish;
   end

endmodule

FILE: multi_channel_periodic_tick_timer_unit.f
+incdir+rtl/core
rtl/core/mctt_pkg.sv
rtl/core/mctt_ifs.sv
rtl/core/mctt_rem_unit.sv
rtl/core/mctt_core.sv
rtl/core/multi_channel_periodic_tick_timer_unit.sv
test/multi_channel_periodic_tick_timer_unit_tb.sv
